/* src/wakf_pkg.sv */
// wakf_pkg: shared types, constants and angle helpers for the wrapped angle kalman filter
// used by wakf_ctrl, wakf_dp and wrapped_angle_kalman_filter; no dependencies
`default_nettype none

package wakf_pkg;

	// field widths
	localparam int ANGLE_W = 16;
	localparam int VAR_W   = 32;
	localparam int AUX_W   = 32;
	localparam int Q_W     = 24;
	localparam int FUNC_W  = 2;
	localparam int GAIN_W  = 16;
	localparam int EXT_W   = 18;   // angle sums and innovation before saturation
	localparam int QUO_W   = 17;   // gain quotient, up to 1.0 in Q1.16
	localparam int DIV_CNT_W = 5;

	localparam logic [Q_W-1:0] Q_ANGLE_RESET = 24'd1678;

	localparam logic signed [EXT_W-1:0] ANG_PI     = 18'sd12868;
	localparam logic signed [EXT_W-1:0] ANG_TWO_PI = 18'sd25736;
	localparam logic signed [EXT_W-1:0] ANG_MAX    = 18'sd32767;
	localparam logic signed [EXT_W-1:0] ANG_MIN    = -18'sd32768;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST_BIT = 5'd16;

	// function codes carried in tuser
	typedef enum logic [FUNC_W-1:0] {
		FUNC_PREDICT = 2'd0,
		FUNC_UPDATE  = 2'd1,
		FUNC_SET     = 2'd2,
		FUNC_NOP     = 2'd3
	} func_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PMUL,
		ST_UINIT,
		ST_DIV,
		ST_CMUL,
		ST_VMUL,
		ST_FIN
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // capture request fields
		logic pred_mul;  // dt * q_angle
		logic div_init;  // start gain divide, latch innovation
		logic div_step;  // one quotient bit
		logic corr_mul;  // gain * innovation
		logic var_mul;   // variance * (1 - gain)
		logic commit;    // write state and result register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic div_last;  // last quotient bit in progress
		logic out_free;  // result register can take a new result
	} sts_t;

	// subtract or add two pi at most once each
	function automatic logic signed [EXT_W-1:0] wrap_angle(input logic signed [EXT_W-1:0] a);
		logic signed [EXT_W-1:0] r;
		r = a;
		if (r > ANG_PI) r = r - ANG_TWO_PI;
		if (r < -ANG_PI) r = r + ANG_TWO_PI;
		return r;
	endfunction

	// clamp to the signed 16-bit angle range
	function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [EXT_W-1:0] a);
		logic signed [ANGLE_W-1:0] r;
		if (a > ANG_MAX) r = 16'sh7FFF;
		else if (a < ANG_MIN) r = 16'sh8000;
		else r = a[ANGLE_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/wrapped_angle_kalman_filter.sv */
// Wrapped-angle scalar kalman filter, top level: stream ports, config port.
// Order from request accept to result valid: set and unused codes commit directly;
// predict multiplies first; update runs the 17-step divider, then both multiplies.
// One request at a time, next accepted the cycle after commit; a held result stalls commit.
// Reset (arst_n low, async): angle and variance 0, q_angle 1678, no result pending.
// Depends on wakf_pkg, wakf_ctrl, wakf_dp.
`default_nettype none

module wrapped_angle_kalman_filter
	import wakf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request stream
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [47:0]        s_tdata,   // [15:0] angle_value, [47:16] aux_value
	input  wire logic [7:0]         s_tuser,   // [1:0] func, [7:2] zero
	// result stream
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [47:0]             m_tdata,   // [15:0] angle_out, [47:16] variance_out
	// q_angle write
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [Q_W-1:0]     cfg_data
);

	cmd_t                      cmd;
	sts_t                      sts;
	logic signed [ANGLE_W-1:0] angle_out;
	logic [VAR_W-1:0]          variance_out;

	assign cfg_ready = 1'b1;

	wakf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (s_tuser[FUNC_W-1:0]),
		.sts      (sts),
		.cmd      (cmd)
	);

	wakf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (s_tuser[FUNC_W-1:0]),
		.angle_value  ($signed(s_tdata[ANGLE_W-1:0])),
		.aux_value    (s_tdata[ANGLE_W+AUX_W-1:ANGLE_W]),
		.cfg_we       (cfg_valid),
		.cfg_data     (cfg_data),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.angle_out    (angle_out),
		.variance_out (variance_out)
	);

	assign m_tdata = {variance_out, angle_out};

endmodule

`default_nettype wire

/* src/wakf_ctrl.sv */
// wakf_ctrl: sequencing state machine for predict, update, set and no-op requests
// depends on wakf_pkg; drives wakf_dp through cmd_t and reads sts_t
`default_nettype none

module wakf_ctrl
	import wakf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [FUNC_W-1:0]     func,
	input  wire sts_t                  sts,
	output cmd_t                       cmd
);

	state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					case (func_t'(func))
						FUNC_PREDICT: state_nxt = ST_PMUL;
						FUNC_UPDATE:  state_nxt = ST_UINIT;
						default:      state_nxt = ST_FIN;
					endcase
				end
			end
			ST_PMUL: begin
				cmd.pred_mul = 1'b1;
				state_nxt    = ST_FIN;
			end
			ST_UINIT: begin
				cmd.div_init = 1'b1;
				state_nxt    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_nxt = ST_CMUL;
			end
			ST_CMUL: begin
				cmd.corr_mul = 1'b1;
				state_nxt    = ST_VMUL;
			end
			ST_VMUL: begin
				cmd.var_mul = 1'b1;
				state_nxt   = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/wakf_dp.sv */
// wakf_dp: filter state, gain divider, multipliers and result register
// depends on wakf_pkg; controlled by wakf_ctrl through cmd_t
`default_nettype none

module wakf_dp
	import wakf_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cmd_t                       cmd,
	output sts_t                            sts,
	input  wire logic [FUNC_W-1:0]          func,
	input  wire logic signed [ANGLE_W-1:0]  angle_value,
	input  wire logic [AUX_W-1:0]           aux_value,
	input  wire logic                       cfg_we,
	input  wire logic [Q_W-1:0]             cfg_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [ANGLE_W-1:0]       angle_out,
	output logic [VAR_W-1:0]                variance_out
);

	// configuration and filter state
	logic [Q_W-1:0]              q_angle_q;
	logic signed [ANGLE_W-1:0]   angle_q;
	logic [VAR_W-1:0]            var_q;

	// captured request
	logic [FUNC_W-1:0]           func_q;
	logic signed [ANGLE_W-1:0]   av_q;
	logic [AUX_W-1:0]            aux_q;

	// working registers
	logic [AUX_W+Q_W-1:0]        inc_prod_q;
	logic [VAR_W+1:0]            rem_q;
	logic [VAR_W:0]              den_q;
	logic [QUO_W-1:0]            quo_q;
	logic [DIV_CNT_W-1:0]        cnt_q;
	logic signed [EXT_W-1:0]     y_q;
	logic signed [QUO_W+EXT_W-1:0] corr_prod_q;
	logic [VAR_W+QUO_W-1:0]      vprod_q;

	// result register
	logic                        out_valid_q;
	logic signed [ANGLE_W-1:0]   out_angle_q;
	logic [VAR_W-1:0]            out_var_q;

	// combinational terms
	logic signed [EXT_W-1:0]     av_ext, ang_ext, ydiff;
	logic [AUX_W+Q_W:0]          inc_rnd;
	logic [VAR_W:0]              inc;
	logic [VAR_W+1:0]            pvar_sum;
	logic [VAR_W-1:0]            pvar;
	logic signed [ANGLE_W-1:0]   pangle;
	logic                        rem_ge;
	logic [GAIN_W-1:0]           gain;
	logic signed [QUO_W-1:0]     gain_s;
	logic [QUO_W-1:0]            vfac;
	logic signed [QUO_W+EXT_W-1:0] corr_rnd;
	logic signed [EXT_W-1:0]     corr;
	logic signed [ANGLE_W-1:0]   uangle;
	logic [VAR_W+QUO_W:0]        vrnd;
	logic [VAR_W-1:0]            uvar;
	logic signed [ANGLE_W-1:0]   angle_nxt;
	logic [VAR_W-1:0]            var_nxt;

	assign av_ext  = EXT_W'(av_q);
	assign ang_ext = EXT_W'(angle_q);
	assign ydiff   = av_ext - ang_ext;

	// predict: rounded variance increment with saturation, wrapped angle
	assign inc_rnd  = {1'b0, inc_prod_q} + (AUX_W+Q_W+1)'(1 << (Q_W - 1));
	assign inc      = inc_rnd[AUX_W+Q_W:Q_W];
	assign pvar_sum = {1'b0, var_q} + {1'b0, inc};
	assign pvar     = (pvar_sum[VAR_W+1:VAR_W] != 2'b00) ? {VAR_W{1'b1}} : pvar_sum[VAR_W-1:0];
	assign pangle   = sat_angle(wrap_angle(ang_ext + av_ext));

	// gain from quotient, zero for a zero denominator, unit gain clipped
	assign rem_ge = (rem_q >= {1'b0, den_q});
	assign gain   = (den_q == '0) ? '0 :
	                (quo_q[QUO_W-1] ? {GAIN_W{1'b1}} : quo_q[GAIN_W-1:0]);
	assign gain_s = $signed({1'b0, gain});
	assign vfac   = (QUO_W'(1) << GAIN_W) - {1'b0, gain};

	// update: rounded correction and variance
	assign corr_rnd = corr_prod_q + (QUO_W+EXT_W)'(1 << (GAIN_W - 1));
	assign corr     = corr_rnd[EXT_W+GAIN_W-1:GAIN_W];
	assign uangle   = sat_angle(wrap_angle(ang_ext + corr));
	assign vrnd     = {1'b0, vprod_q} + (VAR_W+QUO_W+1)'(1 << (GAIN_W - 1));
	assign uvar     = vrnd[VAR_W+GAIN_W-1:GAIN_W];

	// next state by function code
	always_comb begin
		angle_nxt = angle_q;
		var_nxt   = var_q;
		case (func_t'(func_q))
			FUNC_PREDICT: begin
				angle_nxt = pangle;
				var_nxt   = pvar;
			end
			FUNC_UPDATE: begin
				angle_nxt = uangle;
				var_nxt   = uvar;
			end
			FUNC_SET: begin
				angle_nxt = av_q;
				var_nxt   = '0;
			end
			default: begin
				angle_nxt = angle_q;
				var_nxt   = var_q;
			end
		endcase
	end

	// process noise register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_angle_q <= Q_ANGLE_RESET;
		end else if (cfg_we) begin
			q_angle_q <= cfg_data;
		end
	end

	// filter state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q     <= '0;
			var_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				angle_q     <= angle_nxt;
				var_q       <= var_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_angle_q <= angle_nxt;
			out_var_q   <= var_nxt;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			av_q   <= angle_value;
			aux_q  <= aux_value;
		end
	end

	// predict multiplier
	always_ff @(posedge clk) begin
		if (cmd.pred_mul) begin
			inc_prod_q <= {{Q_W{1'b0}}, aux_q} * {{AUX_W{1'b0}}, q_angle_q};
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			cnt_q <= DIV_LAST_BIT;
		end else if (cmd.div_step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= {2'b00, var_q};
			den_q <= {1'b0, var_q} + {1'b0, aux_q};
			quo_q <= '0;
			y_q   <= wrap_angle(ydiff);
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[QUO_W-2:0], rem_ge};
			if (rem_ge) begin
				rem_q <= (rem_q - {1'b0, den_q}) << 1;
			end else begin
				rem_q <= rem_q << 1;
			end
		end
	end

	// update multipliers, one per cycle
	always_ff @(posedge clk) begin
		if (cmd.corr_mul) begin
			corr_prod_q <= (QUO_W+EXT_W)'(gain_s) * (QUO_W+EXT_W)'(y_q);
		end
		if (cmd.var_mul) begin
			vprod_q <= {{QUO_W{1'b0}}, var_q} * {{VAR_W{1'b0}}, vfac};
		end
	end

	assign sts.div_last = (cnt_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign angle_out    = out_angle_q;
	assign variance_out = out_var_q;

endmodule

`default_nettype wire
